[rtl/cpc_pkg.sv]
`default_nettype none

package cpc_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int AXIS_BITS_DEF  = 16;
  localparam int HR_BITS        = 23;
  localparam int REG_IDX_BITS   = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_AXIS_X      = 3'd3,
    REG_AXIS_Y      = 3'd4,
    REG_AXIS_Z      = 3'd5,
    REG_TOOL_HEIGHT = 3'd6,
    REG_TOOL_RADIUS = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    PART_NONE  = 2'd0,
    PART_SHAFT = 2'd1,
    PART_TIP   = 2'd2
  } part_t;

endpackage

`default_nettype wire

[rtl/capsule_point_containment_unit.sv]
`default_nettype none

// Point-in-capsule test for a ball-end tool. One point is taken every clock while
// the output is not stalled, each giving one result (inside_res, hit_part) in
// order; the depth is set by the wide squares (dot product squared, cross product
// terms squared), each done on a two-stage split multiplier. A stall on the output
// freezes the whole pipeline and holds off the input. All comparisons are exact
// on integer squares, with no root or division. Tool registers are written over
// the config port while no point is in flight, by the user; the block does not enforce it.
// Derived products r^2|a|^2 and (h-r)^2|a|^2 are registered via a split multiplier.
module capsule_point_containment_unit #(
  parameter int COORD_BITS = cpc_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS  = cpc_pkg::AXIS_BITS_DEF,
  localparam int CFG_BITS  = (COORD_BITS > cpc_pkg::HR_BITS)
                             ? ((COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS)
                             : ((cpc_pkg::HR_BITS > AXIS_BITS) ? cpc_pkg::HR_BITS
                                                                : AXIS_BITS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_BITS-1:0]      point_x,
  input  logic signed [COORD_BITS-1:0]      point_y,
  input  logic signed [COORD_BITS-1:0]      point_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              inside_res,
  output logic [1:0]                        hit_part,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpc_pkg::REG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]               cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int A     = AXIS_BITS;
  localparam int HR    = cpc_pkg::HR_BITS;
  localparam int DW    = C + 1;
  localparam int PW    = DW + A;
  localparam int DOTW  = PW + 2;
  localparam int CRW   = PW + 1;
  localparam int DOT2W = 2 * DOTW;
  localparam int CR2W  = 2 * CRW;
  localparam int C2W   = CR2W + 2;
  localparam int AAW   = 2 * A;
  localparam int A2W   = AAW + 2;
  localparam int R2W   = 2 * HR;
  localparam int LENW  = HR + 1;
  localparam int RAW   = R2W + A2W;
  localparam int DSQW  = 2 * DW;
  localparam int D2W   = DSQW + 2;
  localparam int DCW   = (D2W > R2W) ? D2W : R2W;
  localparam int CMPW0 = (DOT2W > C2W) ? DOT2W : C2W;
  localparam int CMPW  = (CMPW0 > RAW) ? CMPW0 : RAW;
  localparam logic signed [A-1:0] AXIS_Z_INIT = A'(1) << (A - 2);

  // tool registers
  logic signed [C-1:0]  center_x, center_y, center_z;
  logic signed [A-1:0]  axis_x, axis_y, axis_z;
  logic [HR-1:0]        tool_height, tool_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      center_z    <= '0;
      axis_x      <= '0;
      axis_y      <= '0;
      axis_z      <= AXIS_Z_INIT;
      tool_height <= '0;
      tool_radius <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cpc_pkg::reg_idx_t'(cfg_index))
        cpc_pkg::REG_CENTER_X:    center_x    <= cfg_data[C-1:0];
        cpc_pkg::REG_CENTER_Y:    center_y    <= cfg_data[C-1:0];
        cpc_pkg::REG_CENTER_Z:    center_z    <= cfg_data[C-1:0];
        cpc_pkg::REG_AXIS_X:      axis_x      <= cfg_data[A-1:0];
        cpc_pkg::REG_AXIS_Y:      axis_y      <= cfg_data[A-1:0];
        cpc_pkg::REG_AXIS_Z:      axis_z      <= cfg_data[A-1:0];
        cpc_pkg::REG_TOOL_HEIGHT: tool_height <= cfg_data[HR-1:0];
        cpc_pkg::REG_TOOL_RADIUS: tool_radius <= cfg_data[HR-1:0];
        default: ;
      endcase
    end
  end

  // derived tool terms, free running from the registers
  logic [AAW-1:0]          aa_x, aa_y, aa_z;
  logic [R2W-1:0]          r2;
  logic signed [LENW-1:0]  len;
  logic [A2W-1:0]          a2;
  logic [R2W-1:0]          len2;
  logic                    len_pos;
  logic                    a2_nz;
  logic [RAW-1:0]          ra, la;

  always_ff @(posedge clk) begin
    aa_x    <= $unsigned(AAW'(axis_x) * AAW'(axis_x));
    aa_y    <= $unsigned(AAW'(axis_y) * AAW'(axis_y));
    aa_z    <= $unsigned(AAW'(axis_z) * AAW'(axis_z));
    r2      <= tool_radius * tool_radius;
    len     <= $signed({1'b0, tool_height}) - $signed({1'b0, tool_radius});
    a2      <= A2W'(aa_x) + A2W'(aa_y) + A2W'(aa_z);
    len_pos <= (len > 0);
    len2    <= (len > 0) ? (len[HR-1:0] * len[HR-1:0]) : '0;
    a2_nz   <= (aa_x != '0) || (aa_y != '0) || (aa_z != '0);
  end

  cpc_mul #(.WA(R2W), .WB(A2W)) u_mul_ra (
    .clk(clk), .en(1'b1), .a(r2), .b(a2), .p(ra)
  );

  cpc_mul #(.WA(R2W), .WB(A2W)) u_mul_la (
    .clk(clk), .en(1'b1), .a(len2), .b(a2), .p(la)
  );

  // point pipeline
  logic       en;
  logic [8:1] v;

  assign en        = !(v[8] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], in_valid};
    end
  end

  // stage 1: offset from center
  logic signed [DW-1:0] dx, dy, dz;
  // stage 2: axis products and squares of the offset
  logic signed [PW-1:0] p_xx, p_yy, p_zz, p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [DSQW-1:0] sq_x, sq_y, sq_z;
  // stage 3: dot and cross product, squared offset length
  logic signed [DOTW-1:0] dot;
  logic signed [CRW-1:0]  cr_x, cr_y, cr_z;
  logic [D2W-1:0]         d2;
  // stage 4: magnitudes and early flags
  logic [DOTW-1:0] dot_mag;
  logic [CRW-1:0]  crm_x, crm_y, crm_z;
  logic            dot_pos4, tip_ok4;
  // stages 5 and 6 carry flags alongside the multipliers
  logic            dot_pos5, tip_ok5, dot_pos6, tip_ok6;
  logic [DOT2W-1:0] dot2;
  logic [CR2W-1:0]  crq_x, crq_y, crq_z;
  // stage 7: sum of cross squares, axial limits
  logic [C2W-1:0]  c2;
  logic            dot_pos7, tip_ok7, le_la7, le_ra7;
  // stage 8: result
  cpc_pkg::part_t  part;
  cpc_pkg::part_t  part_next;

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DW'(point_x) - DW'(center_x);
      dy <= DW'(point_y) - DW'(center_y);
      dz <= DW'(point_z) - DW'(center_z);

      p_xx <= PW'(dx) * PW'(axis_x);
      p_yy <= PW'(dy) * PW'(axis_y);
      p_zz <= PW'(dz) * PW'(axis_z);
      p_yz <= PW'(dy) * PW'(axis_z);
      p_zy <= PW'(dz) * PW'(axis_y);
      p_zx <= PW'(dz) * PW'(axis_x);
      p_xz <= PW'(dx) * PW'(axis_z);
      p_xy <= PW'(dx) * PW'(axis_y);
      p_yx <= PW'(dy) * PW'(axis_x);
      sq_x <= DSQW'(dx) * DSQW'(dx);
      sq_y <= DSQW'(dy) * DSQW'(dy);
      sq_z <= DSQW'(dz) * DSQW'(dz);

      dot  <= DOTW'(p_xx) + DOTW'(p_yy) + DOTW'(p_zz);
      cr_x <= CRW'(p_yz) - CRW'(p_zy);
      cr_y <= CRW'(p_zx) - CRW'(p_xz);
      cr_z <= CRW'(p_xy) - CRW'(p_yx);
      d2   <= D2W'($unsigned(sq_x)) + D2W'($unsigned(sq_y)) + D2W'($unsigned(sq_z));

      dot_mag  <= dot[DOTW-1] ? $unsigned(-dot) : $unsigned(dot);
      crm_x    <= cr_x[CRW-1] ? $unsigned(-cr_x) : $unsigned(cr_x);
      crm_y    <= cr_y[CRW-1] ? $unsigned(-cr_y) : $unsigned(cr_y);
      crm_z    <= cr_z[CRW-1] ? $unsigned(-cr_z) : $unsigned(cr_z);
      dot_pos4 <= (dot > 0);
      tip_ok4  <= (DCW'(d2) <= DCW'(r2));

      dot_pos5 <= dot_pos4;
      tip_ok5  <= tip_ok4;
      dot_pos6 <= dot_pos5;
      tip_ok6  <= tip_ok5;

      c2       <= C2W'(crq_x) + C2W'(crq_y) + C2W'(crq_z);
      le_la7   <= (CMPW'(dot2) <= CMPW'(la));
      le_ra7   <= (CMPW'(dot2) <= CMPW'(ra));
      dot_pos7 <= dot_pos6;
      tip_ok7  <= tip_ok6;

      part <= part_next;
    end
  end

  cpc_mul #(.WA(DOTW), .WB(DOTW)) u_mul_dot (
    .clk(clk), .en(en), .a(dot_mag), .b(dot_mag), .p(dot2)
  );

  cpc_mul #(.WA(CRW), .WB(CRW)) u_mul_cx (
    .clk(clk), .en(en), .a(crm_x), .b(crm_x), .p(crq_x)
  );

  cpc_mul #(.WA(CRW), .WB(CRW)) u_mul_cy (
    .clk(clk), .en(en), .a(crm_y), .b(crm_y), .p(crq_y)
  );

  cpc_mul #(.WA(CRW), .WB(CRW)) u_mul_cz (
    .clk(clk), .en(en), .a(crm_z), .b(crm_z), .p(crq_z)
  );

  always_comb begin
    part_next = cpc_pkg::PART_NONE;
    if (a2_nz) begin
      if (dot_pos7) begin
        // shaft region: within axial length and close enough to the axis
        if (len_pos && le_la7 && (CMPW'(c2) <= CMPW'(ra))) begin
          part_next = cpc_pkg::PART_SHAFT;
        end
      end else if (le_ra7 && tip_ok7) begin
        part_next = cpc_pkg::PART_TIP;
      end
    end
  end

  assign hit_part   = part;
  assign inside_res = (part != cpc_pkg::PART_NONE);

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[1])
    else $error("accepted point did not enter the pipeline");

  a_no_false_stall : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result waiting");

  a_part_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit_part == cpc_pkg::PART_NONE || hit_part == cpc_pkg::PART_SHAFT
                   || hit_part == cpc_pkg::PART_TIP))
    else $error("hit_part carries an unused code");

  a_inside_match : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inside_res == (hit_part != cpc_pkg::PART_NONE)))
    else $error("inside_res disagrees with hit_part");

endmodule

`default_nettype wire

[rtl/cpc_mul.sv]
`default_nettype none

// unsigned multiplier split into four half-width partial products,
// two register stages: partial products, then the shifted sum
module cpc_mul #(
  parameter int WA = 2,
  parameter int WB = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int W  = WA + WB;
  localparam int LA = WA / 2;
  localparam int HA = WA - LA;
  localparam int LB = WB / 2;
  localparam int HB = WB - LB;

  logic [LA+LB-1:0] pp_ll;
  logic [LA+HB-1:0] pp_lh;
  logic [HA+LB-1:0] pp_hl;
  logic [HA+HB-1:0] pp_hh;
  logic [W-1:0]     p_next;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[LA-1:0] * b[LB-1:0];
      pp_lh <= a[LA-1:0] * b[WB-1:LB];
      pp_hl <= a[WA-1:LA] * b[LB-1:0];
      pp_hh <= a[WA-1:LA] * b[WB-1:LB];
    end
  end

  always_comb begin
    p_next = (W'(pp_hh) << (LA + LB)) + (W'(pp_hl) << LA)
           + (W'(pp_lh) << LB) + W'(pp_ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= p_next;
    end
  end

endmodule

`default_nettype wire
